### rtl/sdf_pkg.sv
// Types, constants and saturating helpers for the damped spring force block.
// No dependencies; used by every file under rtl.
package sdf_pkg;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int UB = 30;
  localparam int IW = 3;

  typedef logic signed [DW-1:0] sword_t;
  typedef logic        [DW-1:0] uword_t;
  typedef logic signed [DW+1:0] wsum_t;
  typedef logic        [2*DW-1:0] dword_t;

  localparam sword_t SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam sword_t SMIN = {1'b1, {(DW-1){1'b0}}};
  localparam wsum_t  SUM_MAX = {3'b000, {(DW-1){1'b1}}};
  localparam wsum_t  SUM_MIN = {3'b111, {(DW-1){1'b0}}};
  localparam dword_t MAG_MIN = dword_t'(1) << (DW-1);
  localparam dword_t MAG_MAX = MAG_MIN - dword_t'(1);
  localparam sword_t UNIT_ONE = sword_t'(1) << UB;

  localparam logic [IW-1:0] REG_STIFFNESS = 3'd0;
  localparam logic [IW-1:0] REG_DAMPING   = 3'd1;
  localparam logic [IW-1:0] REG_REST      = 3'd2;
  localparam logic [IW-1:0] REG_HALF_STEP = 3'd3;
  localparam logic [IW-1:0] REG_ELASTIC   = 3'd4;
  localparam logic [IW-1:0] REG_MAX_FORCE = 3'd5;

  typedef enum logic [2:0] {
    STAT_APPLIED = 3'd0,
    STAT_SLACK   = 3'd1,
    STAT_BROKE   = 3'd2,
    STAT_CLAMPED = 3'd3,
    STAT_BROKEN  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIFF, ST_SQ, ST_ROOT, ST_DIV, ST_VT,
    ST_F1, ST_F2, ST_F3, ST_LIM, ST_FRC, ST_DONE
  } state_t;

  typedef struct packed {
    sword_t pos_a_x;
    sword_t pos_a_y;
    sword_t pos_a_z;
    sword_t pos_b_x;
    sword_t pos_b_y;
    sword_t pos_b_z;
    sword_t vel_a_x;
    sword_t vel_a_y;
    sword_t vel_a_z;
    sword_t vel_b_x;
    sword_t vel_b_y;
    sword_t vel_b_z;
  } sdf_in_t;

  typedef struct packed {
    sword_t  force_x;
    sword_t  force_y;
    sword_t  force_z;
    status_t status;
  } sdf_out_t;

  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } unit_ctl_t;

  function automatic wsum_t ext2(input sword_t v);
    return {{2{v[DW-1]}}, v};
  endfunction

  function automatic sword_t sat_sum(input wsum_t x);
    if (x > SUM_MAX) return SMAX;
    else if (x < SUM_MIN) return SMIN;
    else return x[DW-1:0];
  endfunction

  function automatic uword_t mag_of(input sword_t v);
    return v[DW-1] ? uword_t'(-v) : uword_t'(v);
  endfunction

  function automatic sword_t sat_mag(input logic neg, input dword_t m);
    if (neg) begin
      if (m > MAG_MIN) return SMIN;
      else return sword_t'(-m[DW-1:0]);
    end else begin
      if (m > MAG_MAX) return SMAX;
      else return sword_t'(m[DW-1:0]);
    end
  endfunction

endpackage

### rtl/sdf_mul.sv
// Shared unsigned multiplier with registered product.
// Depends on sdf_pkg.
module sdf_mul (
  input  logic           clk,
  input  sdf_pkg::uword_t a,
  input  sdf_pkg::uword_t b,
  output sdf_pkg::dword_t p_r
);

  always_ff @(posedge clk) begin
    p_r <= sdf_pkg::dword_t'(a) * sdf_pkg::dword_t'(b);
  end

endmodule

### rtl/sdf_root_div.sv
// Iterative integer square root and restoring divider sharing one subtractor.
// Depends on sdf_pkg.
module sdf_root_div (
  input  logic               clk,
  input  logic               rst_n,
  input  sdf_pkg::unit_ctl_t ctl,
  input  sdf_pkg::dword_t    radicand,
  input  logic [30:0]        num,
  input  sdf_pkg::uword_t    divisor,
  output logic               done,
  output sdf_pkg::uword_t    res
);

  logic            busy_r, done_r, mode_r;
  logic [4:0]      it_r;
  sdf_pkg::dword_t x_r, r_r, bit_r;
  sdf_pkg::dword_t opa, opb;
  logic [64:0]     dif;
  logic            ge, last;

  always_comb begin
    opa  = mode_r ? x_r : {31'b0, x_r[31:0], bit_r[30]};
    opb  = mode_r ? (r_r + bit_r) : {32'b0, divisor};
    dif  = {1'b0, opa} - {1'b0, opb};
    ge   = !dif[64];
    last = (it_r == (mode_r ? 5'd31 : 5'd30));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && last;
      if (ctl.start) busy_r <= 1'b1;
      else if (busy_r && last) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      mode_r <= ctl.sqrt_mode;
      it_r   <= 5'd0;
      r_r    <= '0;
      if (ctl.sqrt_mode) begin
        x_r   <= radicand;
        bit_r <= sdf_pkg::dword_t'(1) << 62;
      end else begin
        x_r   <= {34'b0, num[30:1]};
        bit_r <= {33'b0, num[0], 30'b0};
      end
    end else if (busy_r) begin
      it_r <= it_r + 5'd1;
      if (mode_r) begin
        if (ge) begin
          x_r <= dif[63:0];
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end else begin
        x_r   <= ge ? dif[63:0] : opa;
        r_r   <= {r_r[62:0], ge};
        bit_r <= bit_r << 1;
      end
    end
  end

  assign done = done_r;
  assign res  = r_r[31:0];

endmodule

### rtl/spring_damper_force.sv
// Damped spring force: one word in, one word out.
// Per word: 32 root steps and three 31-step divisions in the shared
// root/divide unit, and shared-multiplier products. A short spring skips the
// divisions; a broken spring skips all arithmetic. Words are taken one at a
// time: in_stall is high until the result is loaded into out_data. Synchronous
// active-low reset clears control, config registers and the broken flag.
module spring_damper_force (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sdf_pkg::sdf_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sdf_pkg::sdf_out_t out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  sdf_pkg::state_t   state_r, state_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              ph_r, ph_nxt;

  logic [30:0]       stiff_r, damp_r, rest_r, half_r;
  logic              el_r;
  sdf_pkg::sword_t   maxf_r;
  logic              broken_r;

  sdf_pkg::sdf_in_t  in_r;
  sdf_pkg::uword_t   mag_r [3];
  logic [2:0]        neg_r;
  logic              s_r;
  sdf_pkg::sword_t   dv_r [3];
  sdf_pkg::dword_t   sum_r;
  sdf_pkg::uword_t   root_r;
  sdf_pkg::sword_t   len_r;
  sdf_pkg::sword_t   u_r [3];
  sdf_pkg::sword_t   vterm_r, fac_r, tmp_r;
  sdf_pkg::sdf_out_t res_r, out_r;
  logic              out_valid_r;

  sdf_pkg::sword_t   pa [3], pb [3], va [3], vb [3];
  logic signed [32:0] dsub [3], dneg [3];
  sdf_pkg::uword_t   mag_c [3];
  sdf_pkg::sword_t   t_c;
  sdf_pkg::sword_t   mul_sa, mul_sb;
  logic              mul_neg;
  sdf_pkg::dword_t   p_r;
  sdf_pkg::sword_t   mq_u, mq_f;
  sdf_pkg::unit_ctl_t ctl;
  logic              u_done;
  sdf_pkg::uword_t   u_res;
  sdf_pkg::sword_t   len_c, q_c;
  logic              short_c, out_free;
  sdf_pkg::uword_t   fac_mag;
  logic              lim_slack, lim_break, lim_clamp;

  always_comb begin
    pa[0] = in_r.pos_a_x; pa[1] = in_r.pos_a_y; pa[2] = in_r.pos_a_z;
    pb[0] = in_r.pos_b_x; pb[1] = in_r.pos_b_y; pb[2] = in_r.pos_b_z;
    va[0] = in_r.vel_a_x; va[1] = in_r.vel_a_y; va[2] = in_r.vel_a_z;
    vb[0] = in_r.vel_b_x; vb[1] = in_r.vel_b_y; vb[2] = in_r.vel_b_z;
    for (int i = 0; i < 3; i++) begin
      dsub[i]  = {pb[i][31], pb[i]} - {pa[i][31], pa[i]};
      dneg[i]  = -dsub[i];
      mag_c[i] = dsub[i][32] ? dneg[i][31:0] : dsub[i][31:0];
    end
  end

  assign t_c      = s_r ? sdf_pkg::sword_t'(mag_r[cnt_r] >> 1) : sdf_pkg::sword_t'(mag_r[cnt_r]);
  assign short_c  = !s_r && (sum_r <= sdf_pkg::dword_t'(1));
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    if (s_r) len_c = (u_res[31:30] != 2'b00) ? sdf_pkg::SMAX : sdf_pkg::sword_t'({u_res[30:0], 1'b0});
    else     len_c = u_res[31] ? sdf_pkg::SMAX : sdf_pkg::sword_t'(u_res);
    q_c = neg_r[cnt_r] ? sdf_pkg::sword_t'(-u_res) : sdf_pkg::sword_t'(u_res);
  end

  assign fac_mag   = sdf_pkg::mag_of(fac_r);
  assign lim_slack = el_r && fac_r[31];
  assign lim_break = !lim_slack && !maxf_r[31] && (maxf_r != '0) &&
                     (fac_mag > sdf_pkg::uword_t'(maxf_r));
  assign lim_clamp = !lim_slack && maxf_r[31] && (fac_mag > sdf_pkg::mag_of(maxf_r));

  assign mul_neg = mul_sa[31] ^ mul_sb[31];
  assign mq_u    = sdf_pkg::sat_mag(mul_neg, p_r >> sdf_pkg::UB);
  assign mq_f    = sdf_pkg::sat_mag(mul_neg, p_r >> sdf_pkg::FB);

  sdf_mul u_mul (
    .clk (clk),
    .a   (sdf_pkg::mag_of(mul_sa)),
    .b   (sdf_pkg::mag_of(mul_sb)),
    .p_r (p_r)
  );

  sdf_root_div u_unit (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .radicand (sum_r),
    .num      (t_c[30:0]),
    .divisor  (root_r),
    .done     (u_done),
    .res      (u_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ph_nxt    = ph_r;
    unique case (state_r)
      sdf_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = broken_r ? sdf_pkg::ST_DONE : sdf_pkg::ST_DIFF;
        cnt_nxt = 2'd0;
        ph_nxt  = 1'b0;
      end
      sdf_pkg::ST_DIFF: state_nxt = sdf_pkg::ST_SQ;
      sdf_pkg::ST_SQ, sdf_pkg::ST_VT, sdf_pkg::ST_FRC: begin
        ph_nxt = !ph_r;
        if (ph_r) begin
          cnt_nxt = cnt_r + 2'd1;
          if (cnt_r == 2'd2) begin
            cnt_nxt = 2'd0;
            unique case (state_r)
              sdf_pkg::ST_SQ: state_nxt = sdf_pkg::ST_ROOT;
              sdf_pkg::ST_VT: state_nxt = sdf_pkg::ST_F1;
              default:        state_nxt = sdf_pkg::ST_DONE;
            endcase
          end
        end
      end
      sdf_pkg::ST_ROOT: begin
        if (!ph_r) ph_nxt = 1'b1;
        else if (u_done) begin
          ph_nxt    = 1'b0;
          state_nxt = short_c ? sdf_pkg::ST_VT : sdf_pkg::ST_DIV;
        end
      end
      sdf_pkg::ST_DIV: begin
        if (!ph_r) ph_nxt = 1'b1;
        else if (u_done) begin
          ph_nxt  = 1'b0;
          cnt_nxt = cnt_r + 2'd1;
          if (cnt_r == 2'd2) begin
            cnt_nxt   = 2'd0;
            state_nxt = sdf_pkg::ST_VT;
          end
        end
      end
      sdf_pkg::ST_F1, sdf_pkg::ST_F2, sdf_pkg::ST_F3: begin
        ph_nxt = !ph_r;
        if (ph_r) begin
          unique case (state_r)
            sdf_pkg::ST_F1: state_nxt = sdf_pkg::ST_F2;
            sdf_pkg::ST_F2: state_nxt = sdf_pkg::ST_F3;
            default:        state_nxt = sdf_pkg::ST_LIM;
          endcase
        end
      end
      sdf_pkg::ST_LIM: state_nxt = (lim_slack || lim_break) ? sdf_pkg::ST_DONE : sdf_pkg::ST_FRC;
      sdf_pkg::ST_DONE: if (out_free) state_nxt = sdf_pkg::ST_IDLE;
      default: state_nxt = sdf_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall      = (state_r != sdf_pkg::ST_IDLE);
    ctl.start     = ((state_r == sdf_pkg::ST_ROOT) || (state_r == sdf_pkg::ST_DIV)) && !ph_r;
    ctl.sqrt_mode = (state_r == sdf_pkg::ST_ROOT);
    mul_sa        = '0;
    mul_sb        = '0;
    unique case (state_r)
      sdf_pkg::ST_SQ:  begin mul_sa = t_c;                     mul_sb = t_c;      end
      sdf_pkg::ST_VT:  begin mul_sa = dv_r[cnt_r];             mul_sb = u_r[cnt_r]; end
      sdf_pkg::ST_F1:  begin mul_sa = {1'b0, half_r};          mul_sb = vterm_r;  end
      sdf_pkg::ST_F2:  begin mul_sa = {1'b0, stiff_r};         mul_sb = fac_r;    end
      sdf_pkg::ST_F3:  begin mul_sa = {1'b0, damp_r};          mul_sb = vterm_r;  end
      sdf_pkg::ST_FRC: begin mul_sa = fac_r;                   mul_sb = u_r[cnt_r]; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sdf_pkg::ST_IDLE;
      cnt_r       <= 2'd0;
      ph_r        <= 1'b0;
      out_valid_r <= 1'b0;
      broken_r    <= 1'b0;
      stiff_r     <= '0;
      damp_r      <= '0;
      rest_r      <= '0;
      half_r      <= '0;
      el_r        <= 1'b0;
      maxf_r      <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ph_r    <= ph_nxt;
      if (state_r == sdf_pkg::ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (state_r == sdf_pkg::ST_LIM && lim_break) broken_r <= 1'b1;
      if (cfg_we) begin
        unique case (cfg_index)
          sdf_pkg::REG_STIFFNESS: stiff_r <= cfg_data[30:0];
          sdf_pkg::REG_DAMPING:   damp_r  <= cfg_data[30:0];
          sdf_pkg::REG_REST:      rest_r  <= cfg_data[30:0];
          sdf_pkg::REG_HALF_STEP: half_r  <= cfg_data[30:0];
          sdf_pkg::REG_ELASTIC:   el_r    <= cfg_data[0];
          sdf_pkg::REG_MAX_FORCE: maxf_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      sdf_pkg::ST_IDLE: begin
        in_r  <= in_data;
        res_r <= '{force_x: '0, force_y: '0, force_z: '0, status: sdf_pkg::STAT_BROKEN};
      end
      sdf_pkg::ST_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          mag_r[i] <= mag_c[i];
          neg_r[i] <= dsub[i][32];
          dv_r[i]  <= sdf_pkg::sat_sum(sdf_pkg::ext2(va[i]) - sdf_pkg::ext2(vb[i]));
        end
        s_r     <= mag_c[0][31] | mag_c[1][31] | mag_c[2][31];
        sum_r   <= '0;
        vterm_r <= '0;
      end
      sdf_pkg::ST_SQ: if (ph_r) sum_r <= sum_r + p_r;
      sdf_pkg::ST_ROOT: begin
        if (ph_r && u_done) begin
          root_r <= u_res;
          len_r  <= len_c;
          if (short_c) begin
            u_r[0] <= sdf_pkg::UNIT_ONE;
            u_r[1] <= '0;
            u_r[2] <= '0;
          end
        end
      end
      sdf_pkg::ST_DIV: if (ph_r && u_done) u_r[cnt_r] <= q_c;
      sdf_pkg::ST_VT: if (ph_r)
        vterm_r <= sdf_pkg::sat_sum(sdf_pkg::ext2(vterm_r) + sdf_pkg::ext2(mq_u));
      sdf_pkg::ST_F1: if (ph_r)
        fac_r <= sdf_pkg::sat_sum(
                   sdf_pkg::ext2(sdf_pkg::sat_sum(sdf_pkg::ext2(len_r) - sdf_pkg::ext2(mq_f)))
                   - sdf_pkg::ext2({1'b0, rest_r}));
      sdf_pkg::ST_F2: if (ph_r) tmp_r <= mq_f;
      sdf_pkg::ST_F3: if (ph_r)
        fac_r <= sdf_pkg::sat_sum(sdf_pkg::ext2(tmp_r) - sdf_pkg::ext2(mq_f));
      sdf_pkg::ST_LIM: begin
        res_r.force_x <= '0;
        res_r.force_y <= '0;
        res_r.force_z <= '0;
        priority if (lim_slack) res_r.status <= sdf_pkg::STAT_SLACK;
        else if (lim_break) res_r.status <= sdf_pkg::STAT_BROKE;
        else if (lim_clamp) begin
          res_r.status <= sdf_pkg::STAT_CLAMPED;
          fac_r <= sdf_pkg::sat_mag(fac_r[31], sdf_pkg::dword_t'(sdf_pkg::mag_of(maxf_r)));
        end else res_r.status <= sdf_pkg::STAT_APPLIED;
      end
      sdf_pkg::ST_FRC: begin
        if (ph_r) begin
          unique case (cnt_r)
            2'd0:    res_r.force_x <= mq_u;
            2'd1:    res_r.force_y <= mq_u;
            default: res_r.force_z <= mq_u;
          endcase
        end
      end
      sdf_pkg::ST_DONE: if (out_free) out_r <= res_r;
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_break_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status == sdf_pkg::STAT_BROKE |-> broken_r)
    else $error("break reported without broken flag");

  a_zero_force: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.status == sdf_pkg::STAT_BROKE || out_r.status == sdf_pkg::STAT_SLACK ||
                    out_r.status == sdf_pkg::STAT_BROKEN)
    |-> out_r.force_x == '0 && out_r.force_y == '0 && out_r.force_z == '0)
    else $error("non-zero force on an unapplied word");

  a_unit_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    u_done |-> state_r == sdf_pkg::ST_ROOT || state_r == sdf_pkg::ST_DIV)
    else $error("root/divide unit finished outside its states");

endmodule

### sim/spring_damper_force_test.sv
// Self-checking testbench for spring_damper_force: random and directed spring words,
// a behavioural force predictor, random input gaps and random output stalls.
// Depends on rtl/sdf_pkg.sv and rtl/spring_damper_force.sv.
`timescale 1ns / 1ps

module spring_damper_force_test;

  localparam longint MAXU = 64'h7FFF_FFFF;
  localparam int WATCHDOG_LIMIT = 40000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  sdf_pkg::sdf_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  sdf_pkg::sdf_out_t out_data;
  logic     cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  spring_damper_force i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state and registers
  longint k_stiff, k_damp, k_rest, k_half, k_max;
  bit     k_elastic, spring_broken;

  sdf_pkg::sdf_in_t  pending_words[$];
  sdf_pkg::sdf_out_t expected_forces[$];
  int fail_count = 0;
  int gap_left = 0, stall_left = 0, idle_cycles = 0;
  bit calm_send = 1'b0, calm_recv = 1'b0;

  function automatic bit [63:0] mag(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint clip(bit neg, bit [63:0] m);
    if (neg) begin
      if (m > 64'h8000_0000) m = 64'h8000_0000;
      return -longint'(m);
    end
    return m > MAXU ? MAXU : longint'(m);
  endfunction

  function automatic longint add_sm(bit na, bit [63:0] ma, bit nb, bit [63:0] mb);
    if (na == nb) return clip(na, ma + mb);
    if (ma >= mb) return clip(na, ma - mb);
    return clip(nb, mb - ma);
  endfunction

  function automatic longint sadd(longint a, longint b);
    return add_sm(a < 0, mag(a), b < 0, mag(b));
  endfunction

  function automatic longint ssub(longint a, longint b);
    return add_sm(a < 0, mag(a), !(b < 0), mag(b));
  endfunction

  function automatic longint qmul(longint a, longint b, int sh);
    bit [127:0] p;
    p = {64'b0, mag(a)} * {64'b0, mag(b)};
    p = p >> sh;
    return clip((a < 0) != (b < 0), p[127:64] != 0 ? {64{1'b1}} : p[63:0]);
  endfunction

  function automatic bit [63:0] root_floor(bit [63:0] x);
    bit [63:0] r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic sdf_pkg::sdf_out_t spring_force(sdf_pkg::sdf_in_t w);
    sdf_pkg::sdf_out_t r;
    longint    pa[3], pb[3], va[3], vb[3], u[3], len, vterm, fac, q;
    bit [63:0] dm[3], mx, sum, root, t;
    bit        dneg[3];
    int        s;
    r = '0;
    if (spring_broken) begin
      r.status = sdf_pkg::STAT_BROKEN;
      return r;
    end
    pa[0] = longint'(w.pos_a_x); pa[1] = longint'(w.pos_a_y); pa[2] = longint'(w.pos_a_z);
    pb[0] = longint'(w.pos_b_x); pb[1] = longint'(w.pos_b_y); pb[2] = longint'(w.pos_b_z);
    va[0] = longint'(w.vel_a_x); va[1] = longint'(w.vel_a_y); va[2] = longint'(w.vel_a_z);
    vb[0] = longint'(w.vel_b_x); vb[1] = longint'(w.vel_b_y); vb[2] = longint'(w.vel_b_z);
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      dneg[i] = pb[i] < pa[i];
      dm[i] = mag(pb[i] - pa[i]);
      if (dm[i] > mx) mx = dm[i];
    end
    s = 0;
    while ((mx >> s) >= 64'h8000_0000) s++;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      t = dm[i] >> s;
      sum += t * t;
    end
    root = root_floor(sum);
    if (s > 0 && root > (MAXU >> s)) len = MAXU;
    else len = clip(1'b0, root << s);
    if (s == 0 && sum <= 1) begin
      u[0] = 64'sh1 << sdf_pkg::UB;
      u[1] = 0;
      u[2] = 0;
    end else begin
      for (int i = 0; i < 3; i++) begin
        q = longint'(((dm[i] >> s) << sdf_pkg::UB) / root);
        u[i] = dneg[i] ? -q : q;
      end
    end
    vterm = 0;
    for (int i = 0; i < 3; i++)
      vterm = sadd(vterm, qmul(ssub(va[i], vb[i]), u[i], sdf_pkg::UB));
    fac = ssub(ssub(len, qmul(k_half, vterm, sdf_pkg::FB)), k_rest);
    fac = ssub(qmul(k_stiff, fac, sdf_pkg::FB), qmul(k_damp, vterm, sdf_pkg::FB));
    if (k_elastic && fac < 0) begin
      r.status = sdf_pkg::STAT_SLACK;
      return r;
    end
    if (k_max > 0 && mag(fac) > mag(k_max)) begin
      spring_broken = 1'b1;
      r.status = sdf_pkg::STAT_BROKE;
      return r;
    end
    r.status = sdf_pkg::STAT_APPLIED;
    if (k_max < 0 && mag(fac) > mag(k_max)) begin
      fac = clip(fac < 0, mag(k_max));
      r.status = sdf_pkg::STAT_CLAMPED;
    end
    r.force_x = sdf_pkg::sword_t'(qmul(fac, u[0], sdf_pkg::UB));
    r.force_y = sdf_pkg::sword_t'(qmul(fac, u[1], sdf_pkg::UB));
    r.force_z = sdf_pkg::sword_t'(qmul(fac, u[2], sdf_pkg::UB));
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    sdf_pkg::sdf_in_t nxt;
    bit      show;
    if (rst_n) begin
      show = in_valid;
      if (in_valid && !in_stall) begin
        expected_forces.push_back(spring_force(in_data));
        show = 1'b0;
        if (!calm_send) begin
          gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                  : $urandom_range(0, 3);
        end
      end
      if (!show) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_words.size() > 0) begin
          nxt = pending_words.pop_front();
          in_data <= nxt;
          show = 1'b1;
        end
      end
      in_valid <= show;
    end
  end

  // monitor
  always @(posedge clk) begin
    sdf_pkg::sdf_out_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_forces.size() == 0) begin
          $error("unexpected result word %h", out_data);
          fail_count++;
        end else begin
          e = expected_forces.pop_front();
          if (out_data.force_x !== e.force_x) begin
            $error("force_x expected %0d actual %0d", e.force_x, out_data.force_x);
            fail_count++;
          end
          if (out_data.force_y !== e.force_y) begin
            $error("force_y expected %0d actual %0d", e.force_y, out_data.force_y);
            fail_count++;
          end
          if (out_data.force_z !== e.force_z) begin
            $error("force_z expected %0d actual %0d", e.force_z, out_data.force_z);
            fail_count++;
          end
          if (out_data.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, out_data.status);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm_recv && $urandom_range(0, 3) == 0) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80)
                                                : $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n ||
        (pending_words.size() == 0 && expected_forces.size() == 0 && !in_valid)) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      sdf_pkg::REG_STIFFNESS: k_stiff = longint'(val[30:0]);
      sdf_pkg::REG_DAMPING:   k_damp = longint'(val[30:0]);
      sdf_pkg::REG_REST:      k_rest = longint'(val[30:0]);
      sdf_pkg::REG_HALF_STEP: k_half = longint'(val[30:0]);
      sdf_pkg::REG_ELASTIC:   k_elastic = val[0];
      sdf_pkg::REG_MAX_FORCE: k_max = longint'(signed'(val));
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_spring(logic [31:0] k, logic [31:0] c, logic [31:0] l,
                            logic [31:0] h, logic [31:0] el, logic [31:0] mf);
    write_reg(sdf_pkg::REG_STIFFNESS, k);
    write_reg(sdf_pkg::REG_DAMPING, c);
    write_reg(sdf_pkg::REG_REST, l);
    write_reg(sdf_pkg::REG_HALF_STEP, h);
    write_reg(sdf_pkg::REG_ELASTIC, el);
    write_reg(sdf_pkg::REG_MAX_FORCE, mf);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_words.size() != 0 || in_valid || expected_forces.size() != 0);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [31:0] any_word(int range_sel);
    case (range_sel)
      0: return $urandom();
      1: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  function automatic sdf_pkg::sdf_in_t random_word();
    sdf_pkg::sdf_in_t w;
    int      sel;
    sel = $urandom_range(0, 5);
    w.pos_a_x = any_word(sel == 0 ? 0 : 1);
    w.pos_a_y = any_word(sel == 0 ? 0 : 1);
    w.pos_a_z = any_word(sel == 0 ? 0 : 1);
    if (sel <= 1) begin
      w.pos_b_x = any_word(0);
      w.pos_b_y = any_word(0);
      w.pos_b_z = any_word(0);
    end else begin
      w.pos_b_x = w.pos_a_x + any_word(2);
      w.pos_b_y = w.pos_a_y + any_word(2);
      w.pos_b_z = w.pos_a_z + any_word(2);
      if (sel == 5) begin
        w.pos_b_x = w.pos_a_x + $urandom_range(0, 2) - 1;
        w.pos_b_y = w.pos_a_y + (($urandom_range(0, 1) == 0) ? 0 : 1);
        w.pos_b_z = w.pos_a_z;
      end
    end
    sel = $urandom_range(0, 3);
    w.vel_a_x = any_word(sel == 0 ? 0 : 2);
    w.vel_a_y = any_word(sel == 0 ? 0 : 2);
    w.vel_a_z = any_word(sel == 0 ? 0 : 2);
    if ($urandom_range(0, 2) == 0) begin
      w.vel_b_x = 0;
      w.vel_b_y = 0;
      w.vel_b_z = 0;
    end else begin
      w.vel_b_x = any_word(sel == 0 ? 0 : 2);
      w.vel_b_y = any_word(sel == 0 ? 0 : 2);
      w.vel_b_z = any_word(sel == 0 ? 0 : 2);
    end
    return w;
  endfunction

  function automatic sdf_pkg::sdf_in_t pair(sdf_pkg::sword_t ax, sdf_pkg::sword_t bx,
                                            sdf_pkg::sword_t by, sdf_pkg::sword_t va);
    sdf_pkg::sdf_in_t w;
    w = '0;
    w.pos_a_x = ax;
    w.pos_b_x = bx;
    w.pos_b_y = by;
    w.vel_a_x = va;
    w.vel_a_y = -va;
    return w;
  endfunction

  task automatic random_burst(int n);
    repeat (n) pending_words.push_back(random_word());
    wait_drained();
  endtask

  task automatic random_spring();
    set_spring($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h0008_0000),
               $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h0002_0000),
               $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h0004_0000),
               $urandom_range(0, 32'h0000_4000), $urandom_range(0, 1),
               -$urandom_range(1, 32'h0010_0000));
  endtask

  initial begin
    sdf_pkg::sdf_in_t w;
    k_stiff = 0; k_damp = 0; k_rest = 0; k_half = 0; k_max = 0;
    k_elastic = 1'b0; spring_broken = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed words at reset settings, then with a working spring
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) set_spring(32'h0001_0000, 32'h0000_8000, 32'h0002_0000,
                                32'h0000_0800, 32'd0, 32'd0);
      pending_words.push_back('0);
      pending_words.push_back(pair(0, 1, 0, 0));
      pending_words.push_back(pair(0, 1, 1, 32'h0001_0000));
      pending_words.push_back(pair(5, 3, 0, 0));
      pending_words.push_back(pair(sdf_pkg::SMIN, sdf_pkg::SMAX, sdf_pkg::SMAX,
                                   sdf_pkg::SMAX));
      pending_words.push_back(pair(sdf_pkg::SMAX, sdf_pkg::SMIN, sdf_pkg::SMIN,
                                   sdf_pkg::SMIN));
      pending_words.push_back(pair(0, 32'h0003_0000, 32'h0004_0000, 32'hFFFF_0000));
      w = '1;
      pending_words.push_back(w);
      w = {12{sdf_pkg::SMIN}};
      w.pos_b_x = sdf_pkg::SMAX;
      pending_words.push_back(w);
      pending_words.push_back(random_word());
      wait_drained();
    end

    // unknown register indexes must leave the spring alone
    write_reg(3'd6, 32'hFFFF_FFFF);
    write_reg(3'd7, 32'hFFFF_FFFF);
    random_burst(200);

    // slack and clamping
    set_spring(32'h0002_0000, 32'h0001_0000, 32'h0001_8000, 32'h0000_1000,
               32'd1, 32'hFFFF_8000);
    random_burst(220);

    // one word at a time, sender waiting for each result
    calm_recv = 1'b1;
    repeat (15) begin
      pending_words.push_back(random_word());
      wait_drained();
    end
    calm_recv = 1'b0;

    // extremes
    set_spring(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'd0, 32'h8000_0000);
    random_burst(150);
    set_spring(32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'hFFFF_FFFF);
    calm_send = 1'b1;
    random_burst(150);
    calm_send = 1'b0;

    repeat (5) begin
      random_spring();
      random_burst(180);
    end

    // break limit: once it trips, every later word reports a broken spring
    set_spring(32'h0001_0000, 32'h0000_4000, 32'h0001_0000, 32'h0000_0800,
               32'd0, 32'h7FFF_FFFF);
    random_burst(30);
    write_reg(sdf_pkg::REG_MAX_FORCE, 32'h0000_4000);
    random_burst(150);

    wait_drained();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
